/* rtl/core/sust_pkg.sv */
// shared types and codes for the sorted unique set table
// no dependencies; used by sust_step and sorted_unique_set_table
package sust_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int DATA_W       = 32;
    localparam int ACTION_W     = 2;
    localparam int STATUS_W     = 3;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_INSERT  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READOUT = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_LISTED    = 3'd6;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    // decision for one scanned entry
    typedef struct packed {
        logic                emit;
        logic                done;
        logic                last;
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   res_value;
        logic                wr_en;
        logic                wr_prev;
        logic [DATA_W-1:0]   wr_data;
        logic                set_flag;
        logic                load_carry;
        logic                cnt_inc;
        logic                cnt_dec;
    } step_t;

endpackage

/* rtl/core/sust_step.sv */
// per-entry decision logic for insert, delete and readout scans
// depends on sust_pkg for codes and the step_t decision struct
module sust_step
    import sust_pkg::*;
(
    input  logic [ACTION_W-1:0]      op,
    input  logic signed [DATA_W-1:0] entry,
    input  logic signed [DATA_W-1:0] operand,
    input  logic [DATA_W-1:0]        carry,
    input  logic                     flag,
    input  logic                     at_end,
    input  logic                     at_last,
    input  logic                     full,
    output step_t                    step
);

    always_comb
    begin
        step           = '0;
        step.last      = 1'b1;
        step.res_value = operand;
        unique case (op)
            // ascending scan, shift the tail up once the slot is found
            ACT_INSERT:
            begin
                if (at_end)
                begin
                    step.emit = 1'b1;
                    step.done = 1'b1;
                    if (full)
                    begin
                        step.status = ST_FULL;
                    end
                    else
                    begin
                        step.status  = ST_INSERTED;
                        step.wr_en   = 1'b1;
                        step.wr_data = flag ? carry : operand;
                        step.cnt_inc = 1'b1;
                    end
                end
                else if (flag)
                begin
                    step.wr_en      = 1'b1;
                    step.wr_data    = carry;
                    step.load_carry = 1'b1;
                end
                else if (entry == operand)
                begin
                    step.emit   = 1'b1;
                    step.done   = 1'b1;
                    step.status = ST_DUPLICATE;
                end
                else if (entry > operand)
                begin
                    if (full)
                    begin
                        step.emit   = 1'b1;
                        step.done   = 1'b1;
                        step.status = ST_FULL;
                    end
                    else
                    begin
                        step.wr_en      = 1'b1;
                        step.wr_data    = operand;
                        step.load_carry = 1'b1;
                        step.set_flag   = 1'b1;
                    end
                end
            end
            // ascending scan, close the gap once the match is found
            ACT_DELETE:
            begin
                if (at_end)
                begin
                    step.emit    = 1'b1;
                    step.done    = 1'b1;
                    step.status  = flag ? ST_REMOVED : ST_NOT_FOUND;
                    step.cnt_dec = flag;
                end
                else if (flag)
                begin
                    step.wr_en   = 1'b1;
                    step.wr_prev = 1'b1;
                    step.wr_data = entry;
                end
                else if (entry == operand)
                begin
                    step.set_flag = 1'b1;
                end
            end
            // one listed element per entry
            ACT_READOUT:
            begin
                step.emit      = 1'b1;
                step.done      = at_last;
                step.last      = at_last;
                step.status    = ST_LISTED;
                step.res_value = entry;
            end
            default:
            begin
                step.done = 1'b1;
            end
        endcase
    end

endmodule

/* rtl/core/sorted_unique_set_table.sv */
// top level of the sorted unique set table: store memory, scan controller
// depends on sust_pkg and sust_step
//
// channel   direction  ports                       transaction
// command   in         start, busy, action, value  start high while busy low
// result    out        strobe, status, value_res,  one cycle per strobe,
//                      last                        no back-pressure
//
// insert scans the stored entries in ascending order, stopping early on
// a duplicate or a full store; delete and readout scan every stored entry, an empty
// store answers a delete or readout without a scan, an ignored action gives no result; one store read per cycle
// each result is registered and appears in the cycle after the one that decides it
// reset clears the entry count and the controller, not the store
// results cannot be stalled; busy stays high until the last one is decided
module sorted_unique_set_table
    import sust_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [ACTION_W-1:0]      action,
    input  logic signed [DATA_W-1:0] value,
    output logic                     strobe,
    output logic [STATUS_W-1:0]      status,
    output logic signed [DATA_W-1:0] value_res,
    output logic                     last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [ACTION_W-1:0] op_reg, op_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [DATA_W-1:0]   carry_reg, carry_next;
    logic                flag_reg, flag_next;

    logic                strobe_reg, strobe_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0]   res_reg, res_next;
    logic                last_reg, last_next;

    logic [DATA_W-1:0]   mem [CAPACITY];
    logic [DATA_W-1:0]   rdata_reg;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic                wr_en;
    logic [CW-1:0]       idx_inc;
    logic [CW-1:0]       idx_dec;
    logic                accept;
    step_t               step;

    assign accept  = start && (state_reg == S_IDLE);
    assign idx_inc = idx_reg + CW'(1);
    assign idx_dec = idx_reg - CW'(1);

    // decision for the entry now in the read register
    sust_step u_step (
        .op      (op_reg),
        .entry   (rdata_reg),
        .operand (val_reg),
        .carry   (carry_reg),
        .flag    (flag_reg),
        .at_end  (idx_reg == count_reg),
        .at_last (idx_inc == count_reg),
        .full    (count_reg == CAP_CNT),
        .step    (step)
    );

    // store addressing
    assign rd_addr = (state_reg == S_SCAN) ? idx_inc[AW-1:0] : '0;
    assign wr_addr = step.wr_prev ? idx_dec[AW-1:0] : idx_reg[AW-1:0];
    assign wr_en   = (state_reg == S_SCAN) && step.wr_en;

    // store memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= step.wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // controller next state
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        op_next     = op_reg;
        val_next    = val_reg;
        carry_next  = carry_reg;
        flag_next   = flag_reg;
        strobe_next = 1'b0;
        status_next = status_reg;
        res_next    = res_reg;
        last_next   = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = action;
                    val_next  = value;
                    idx_next  = '0;
                    flag_next = 1'b0;
                    priority if (action == ACT_NONE)
                    begin
                        state_next = S_IDLE;
                    end
                    else if ((action != ACT_INSERT) && (count_reg == '0))
                    begin
                        // nothing stored: delete and readout answer at once
                        strobe_next = 1'b1;
                        status_next = ST_EMPTY;
                        res_next    = (action == ACT_READOUT) ? '0 : value;
                        last_next   = 1'b1;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                idx_next = idx_inc;
                if (step.set_flag)
                begin
                    flag_next = 1'b1;
                end
                if (step.load_carry)
                begin
                    carry_next = rdata_reg;
                end
                if (step.cnt_inc)
                begin
                    count_next = count_reg + CW'(1);
                end
                if (step.cnt_dec)
                begin
                    count_next = count_reg - CW'(1);
                end
                if (step.emit)
                begin
                    strobe_next = 1'b1;
                    status_next = step.status;
                    res_next    = step.res_value;
                    last_next   = step.last;
                end
                if (step.done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        op_reg     <= op_next;
        val_reg    <= val_next;
        carry_reg  <= carry_next;
        flag_reg   <= flag_next;
        status_reg <= status_next;
        res_reg    <= res_next;
        last_reg   <= last_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign strobe    = strobe_reg;
    assign status    = status_reg;
    assign value_res = res_reg;
    assign last      = last_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_count_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> strobe_reg)
        else $error("entry count changed without a result");

    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && !last_reg |-> busy)
        else $error("non-final result while idle");

    a_none_silent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (action == ACT_NONE) |=> !strobe_reg && !busy)
        else $error("ignored action produced activity");

endmodule

/* tb/sorted_unique_set_table_chk.sv */
`timescale 1ns / 1ps
// checker for the sorted unique set table: predicts the result transactions of
// every accepted command and compares them with what the block emits
// depends on sust_pkg
module sorted_unique_set_table_chk
    import sust_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [ACTION_W-1:0]      action,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     strobe,
    input  logic [STATUS_W-1:0]      status,
    input  logic signed [DATA_W-1:0] value_res,
    input  logic                     last,
    output int                       mismatch_count,
    output int                       results_owed
);

    typedef struct {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } set_result_t;

    // predicted contents of the set, ascending in entries 0 .. member_count-1
    logic signed [DATA_W-1:0] members [CAPACITY];
    int                       member_count;
    set_result_t              owed_q [$];

    task automatic owe(input logic [STATUS_W-1:0] st, input logic signed [DATA_W-1:0] v,
                       input logic lst);
        set_result_t r;
        r.status = st;
        r.value  = v;
        r.last   = lst;
        owed_q.push_back(r);
    endtask

    // apply one command to the predicted set and queue the results it causes
    task automatic predict_command(input logic [ACTION_W-1:0] act,
                                   input logic signed [DATA_W-1:0] operand);
        int pos;
        int i;
        pos = 0;
        case (act)
            ACT_INSERT:
            begin
                while (pos < member_count && members[pos] < operand)
                    pos++;
                // a duplicate is reported even when the set is full
                if (pos < member_count && members[pos] == operand)
                    owe(ST_DUPLICATE, operand, 1'b1);
                else if (member_count >= CAPACITY)
                    owe(ST_FULL, operand, 1'b1);
                else
                begin
                    for (i = member_count; i > pos; i--)
                        members[i] = members[i-1];
                    members[pos] = operand;
                    member_count++;
                    owe(ST_INSERTED, operand, 1'b1);
                end
            end
            ACT_DELETE:
            begin
                if (member_count == 0)
                    owe(ST_EMPTY, operand, 1'b1);
                else
                begin
                    while (pos < member_count && members[pos] != operand)
                        pos++;
                    if (pos >= member_count)
                        owe(ST_NOT_FOUND, operand, 1'b1);
                    else
                    begin
                        // close the gap left by the removed entry
                        for (i = pos; i + 1 < member_count; i++)
                            members[i] = members[i+1];
                        member_count--;
                        owe(ST_REMOVED, operand, 1'b1);
                    end
                end
            end
            ACT_READOUT:
            begin
                if (member_count == 0)
                    owe(ST_EMPTY, '0, 1'b1);
                else
                    for (i = 0; i < member_count; i++)
                        owe(ST_LISTED, members[i], i == member_count - 1);
            end
            default:
            begin
                // unused action code leaves the set alone
            end
        endcase
    endtask

    // result comparison first, then prediction of a newly accepted command
    always @(posedge clk or negedge rst_n)
    begin : watch
        set_result_t want;
        int          new_fails;
        if (!rst_n)
        begin
            member_count = 0;
            owed_q.delete();
            mismatch_count <= 0;
            results_owed   <= 0;
        end
        else
        begin
            new_fails = 0;
            if (strobe)
            begin
                if (owed_q.size() == 0)
                begin
                    $display("%0t: unexpected result transaction status %0d value %0d last %0d",
                             $time, status, value_res, last);
                    new_fails++;
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, status);
                        new_fails++;
                    end
                    if (value_res !== want.value)
                    begin
                        $display("%0t: value_res expected %0d actual %0d",
                                 $time, want.value, value_res);
                        new_fails++;
                    end
                    if (last !== want.last)
                    begin
                        $display("%0t: last expected %0d actual %0d",
                                 $time, want.last, last);
                        new_fails++;
                    end
                end
            end
            if (start && !busy)
                predict_command(action, value);
            mismatch_count <= mismatch_count + new_fails;
            results_owed   <= owed_q.size();
        end
    end

endmodule

/* tb/sorted_unique_set_table_tb.sv */
`timescale 1ns / 1ps
// testbench top for the sorted unique set table: clock, reset, command stimulus
// and final verdict; depends on sust_pkg, sorted_unique_set_table and
// sorted_unique_set_table_chk
module sorted_unique_set_table_tb;

    import sust_pkg::*;

    localparam int CAPACITY    = 32;
    localparam int ITEM_TARGET = 330;
    localparam int TAIL_CYCLES = CAPACITY + 8;
    localparam int POOL_SIZE   = 48;

    localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    logic                     clk    = 1'b0;
    logic                     rst_n  = 1'b0;
    logic                     start  = 1'b0;
    logic [ACTION_W-1:0]      action = ACT_INSERT;
    logic signed [DATA_W-1:0] value  = '0;
    logic                     busy;
    logic                     strobe;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] value_res;
    logic                     last;
    int                       mismatch_count;
    int                       results_owed;

    // operands drawn from a small pool so that duplicates and hits are common
    logic signed [DATA_W-1:0] operand_pool [POOL_SIZE];
    bit                       gaps_on;

    sorted_unique_set_table #(
        .CAPACITY (CAPACITY)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .value     (value),
        .strobe    (strobe),
        .status    (status),
        .value_res (value_res),
        .last      (last)
    );

    sorted_unique_set_table_chk #(
        .CAPACITY (CAPACITY)
    ) chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .value          (value),
        .strobe         (strobe),
        .status         (status),
        .value_res      (value_res),
        .last           (last),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin : watchdog
        #4_000_000;
        $display("sorted_unique_set_table verification failed");
        $finish;
    end

    // present one command, hold it until accepted, then maybe pause
    task automatic send(input logic [ACTION_W-1:0] act, input logic signed [DATA_W-1:0] operand);
        int roll;
        int gap;
        start  <= 1'b1;
        action <= act;
        value  <= operand;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        roll = $urandom_range(0, 99);
        if (!gaps_on || roll < 40)
            gap = 0;
        else if (roll < 85)
            gap = $urandom_range(1, 3);
        else if (roll < 95)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 45);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_operand();
        if ($urandom_range(0, 99) < 70)
            return operand_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    initial
    begin : stimulus
        int                  counted;
        int                  phase;
        int                  k;
        int                  roll;
        bit                  filling;
        logic [ACTION_W-1:0] act;

        operand_pool[0] = VALUE_MIN;
        operand_pool[1] = VALUE_MAX;
        operand_pool[2] = 0;
        operand_pool[3] = -1;
        operand_pool[4] = 1;
        operand_pool[5] = VALUE_MIN + 1;
        for (k = 6; k < POOL_SIZE; k++)
            if (k % 2 == 0)
                operand_pool[k] = $signed($urandom_range(0, 400)) - 200;
            else
                operand_pool[k] = $urandom;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store, extremes, duplicates, head, tail and middle removal
        gaps_on = 1'b1;
        send(ACT_READOUT, 32'sh0);
        send(ACT_DELETE, VALUE_MIN);
        send(ACT_INSERT, 32'sh0);
        send(ACT_INSERT, VALUE_MAX);
        send(ACT_INSERT, VALUE_MIN);
        send(ACT_INSERT, -32'sd1);
        send(ACT_INSERT, 32'sd1);
        send(ACT_INSERT, VALUE_MAX);
        send(ACT_INSERT, -32'sd1);
        send(ACT_DELETE, 32'sh5555_5555);
        send(ACT_READOUT, 32'shFFFF_FFFF);
        send(ACT_NONE, 32'shAAAA_AAAA);
        send(ACT_DELETE, VALUE_MIN);
        send(ACT_DELETE, VALUE_MAX);
        send(ACT_DELETE, 32'sh0);
        send(ACT_READOUT, 32'sh5555_5555);
        send(ACT_DELETE, -32'sd1);
        send(ACT_DELETE, 32'sd1);
        send(ACT_READOUT, 32'shAAAA_AAAA);
        send(ACT_DELETE, 32'sd7);

        // random: alternate fill and drain phases so the set swings to full and back
        counted = 0;
        phase   = 0;
        while (counted < ITEM_TARGET)
        begin
            filling = (phase % 2 == 0);
            gaps_on = (phase % 3 != 2);
            for (k = 0; k < 80 && counted < ITEM_TARGET; k++)
            begin
                roll = $urandom_range(0, 99);
                if (filling)
                    act = (roll < 78) ? ACT_INSERT : (roll < 88) ? ACT_DELETE :
                          (roll < 97) ? ACT_READOUT : ACT_NONE;
                else
                    act = (roll < 15) ? ACT_INSERT : (roll < 80) ? ACT_DELETE :
                          (roll < 97) ? ACT_READOUT : ACT_NONE;
                if (act != ACT_NONE)
                    counted++;
                send(act, pick_operand());
            end
            phase++;
        end

        // drain outstanding results, then watch for stray ones
        start <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("sorted_unique_set_table verification clean");
        else
            $display("sorted_unique_set_table verification failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/sust_pkg.sv
rtl/core/sust_step.sv
rtl/core/sorted_unique_set_table.sv
tb/sorted_unique_set_table_chk.sv
tb/sorted_unique_set_table_tb.sv
